@@ hw/rtl/notch_filtered_pid_speed_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for notch_filtered_pid_speed
// Clocked on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NOTCH_FILTERED_PID_SPEED_DEFINES_SVH
`define NOTCH_FILTERED_PID_SPEED_DEFINES_SVH

// same-cycle implication
`define NCPID_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NCPID_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ncpid_pkg.sv @@
// ----------------------------------------------------------------------------
// ncpid_pkg
// Types, constants and the control store of the notch-filtered PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncpid_pkg;

	// fixed-point format
	localparam int FRAC_BITS = 14;
	localparam int SIG_W     = 40;
	localparam int MUL_B_W   = 23;
	localparam int PROD_W    = SIG_W + MUL_B_W;
	localparam int ACC_W     = 64;

	// field and register widths
	localparam int MM_W       = 16;
	localparam int OUT_W      = 10;
	localparam int GAIN_W     = 22;
	localparam int LIM_W      = 30;
	localparam int DT_W       = 16;
	localparam int COEF_W     = 17;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_W     = 5;

	localparam logic [MM_W-1:0] INVALID_MM = MM_W'(8190);
	localparam int SPEED_LIMIT = 400;

	localparam int ONE    = 1 << FRAC_BITS;
	localparam int K_HOLD = (7 * ONE + 5) / 10;
	localparam int K_NEW  = (3 * ONE + 5) / 10;

	localparam logic signed [MUL_B_W-1:0] ONE_B    = MUL_B_W'(ONE);
	localparam logic signed [MUL_B_W-1:0] KHOLD_B  = MUL_B_W'(K_HOLD);
	localparam logic signed [MUL_B_W-1:0] KNEW_B   = MUL_B_W'(K_NEW);
	localparam logic signed [MUL_B_W-1:0] DT_ONE_B = MUL_B_W'(1 << DT_W);

	localparam logic signed [ACC_W-1:0] SIG_MAX64 = (ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SIG_MIN64 = -SIG_MAX64 - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] CMD_CAP   = ACC_W'(SPEED_LIMIT) <<< (2 * FRAC_BITS);
	localparam logic signed [ACC_W-1:0] CMD_CAP_N = -CMD_CAP;
	localparam logic signed [OUT_W-1:0] CMD_MAX   = OUT_W'(SPEED_LIMIT);
	localparam logic signed [OUT_W-1:0] CMD_MIN   = -CMD_MAX;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P   = 3'd0,
		CFG_GAIN_I   = 3'd1,
		CFG_GAIN_D   = 3'd2,
		CFG_INT_LIM  = 3'd3,
		CFG_DT       = 3'd4,
		CFG_NOTCH_B1 = 3'd5,
		CFG_NOTCH_A1 = 3'd6,
		CFG_NOTCH_A2 = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        gain_p;
		logic [GAIN_W-1:0]        gain_i;
		logic [GAIN_W-1:0]        gain_d_per_dt;
		logic [LIM_W-1:0]         integral_limit;
		logic [DT_W-1:0]          sample_period;
		logic signed [COEF_W-1:0] notch_b1;
		logic signed [COEF_W-1:0] notch_a1;
		logic signed [COEF_W-1:0] notch_a2;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_p:         GAIN_W'(19661),
		gain_i:         GAIN_W'(0),
		gain_d_per_dt:  GAIN_W'(245760),
		integral_limit: LIM_W'(3276800),
		sample_period:  DT_W'(1311),
		notch_b1:       -COEF_W'(32364),
		notch_a1:       -COEF_W'(30746),
		notch_a2:       COEF_W'(14787)
	};

	// multiplier operand A: a 40-bit signal
	typedef enum logic [2:0] {
		A_X, A_IN1, A_IN2, A_Y1, A_Y2, A_PREV, A_SMOOTH, A_INTEG
	} a_sel_t;

	// multiplier operand B: a coefficient, gain or constant
	typedef enum logic [3:0] {
		B_ONE, B_B1, B_A1, B_A2, B_KHOLD, B_KNEW, B_DT, B_TWO16, B_GP, B_GI, B_GD
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_NOTCH, WB_SMOOTH, WB_INTEG, WB_OUT
	} wb_t;

	typedef enum logic [1:0] {
		SEQ_NEXT, SEQ_JDROP, SEQ_DONE
	} seq_op_t;

	typedef struct packed {
		a_sel_t              a;
		b_sel_t              b;
		acc_op_t             acc;
		wb_t                 wb;
		seq_op_t             seq;
		logic [STEP_W-1:0]   target;
	} ucw_t;

	typedef struct packed {
		logic load;
		logic run;
		ucw_t uw;
	} dp_ctl_t;

	localparam logic [STEP_W-1:0] STEP_DROP = STEP_W'(16);

	function automatic ucw_t uword(input a_sel_t a, input b_sel_t b, input acc_op_t acc,
			input wb_t wb, input seq_op_t seq);
		ucw_t w;
		w.a      = a;
		w.b      = b;
		w.acc    = acc;
		w.wb     = wb;
		w.seq    = seq;
		w.target = STEP_DROP;
		return w;
	endfunction

	// control store; the product of step n is consumed by the accumulator at step n+1
	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		unique case (step)
			// notch: x*1 + x2*1 + b1*x1 - a1*y1 - a2*y2
			STEP_W'(0):  w = uword(A_X,      B_ONE,   ACC_NOP,  WB_NONE,   SEQ_JDROP);
			STEP_W'(1):  w = uword(A_IN2,    B_ONE,   ACC_LOAD, WB_NONE,   SEQ_NEXT);
			STEP_W'(2):  w = uword(A_IN1,    B_B1,    ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(3):  w = uword(A_Y1,     B_A1,    ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(4):  w = uword(A_Y2,     B_A2,    ACC_SUB,  WB_NONE,   SEQ_NEXT);
			STEP_W'(5):  w = uword(A_Y2,     B_A2,    ACC_SUB,  WB_NONE,   SEQ_NEXT);
			// smoothed difference: khold*s + knew*y - knew*prev
			STEP_W'(6):  w = uword(A_SMOOTH, B_KHOLD, ACC_NOP,  WB_NOTCH,  SEQ_NEXT);
			STEP_W'(7):  w = uword(A_PREV,   B_KNEW,  ACC_LOAD, WB_NONE,   SEQ_NEXT);
			STEP_W'(8):  w = uword(A_Y1,     B_KNEW,  ACC_SUB,  WB_NONE,   SEQ_NEXT);
			// integral: I*2^16 + y*dt, shifted right by 16 bits
			STEP_W'(9):  w = uword(A_INTEG,  B_TWO16, ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(10): w = uword(A_Y1,     B_DT,    ACC_LOAD, WB_SMOOTH, SEQ_NEXT);
			// command: kp*y + kd*s + ki*I
			STEP_W'(11): w = uword(A_Y1,     B_GP,    ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(12): w = uword(A_SMOOTH, B_GD,    ACC_LOAD, WB_INTEG,  SEQ_NEXT);
			STEP_W'(13): w = uword(A_INTEG,  B_GI,    ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(14): w = uword(A_INTEG,  B_GI,    ACC_ADD,  WB_NONE,   SEQ_NEXT);
			STEP_W'(15): w = uword(A_INTEG,  B_GI,    ACC_NOP,  WB_OUT,    SEQ_DONE);
			// dropped sample lands here
			default:     w = uword(A_X,      B_ONE,   ACC_NOP,  WB_NONE,   SEQ_DONE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/notch_filtered_pid_speed.sv @@
// ----------------------------------------------------------------------------
// notch_filtered_pid_speed
// PID speed controller with a biquad notch on the distance error.
// ----------------------------------------------------------------------------
// Each input transfer is one sample period. A sample with timed_out set or a
// measurement of 8190 mm or more is thrown away: no result, no state change,
// and the next sample is taken once the sequencer has passed its drop step. A
// good sample runs a 16-step microprogram on one shared 40x23 multiplier feeding
// a 64-bit accumulator, one product per step; its result is written to the
// output register at the last step, which also frees the input, and no new
// input is taken while the program runs. The multiplier and the length of the
// program set the sample rate. The next sample is taken while a result is still
// waiting; if that result is still not taken when the following one is ready,
// the program holds at its last step. Configuration must be written only while
// idle (the block itself does not enforce this) and takes effect on the next sample.
// ----------------------------------------------------------------------------
`default_nettype none
`include "notch_filtered_pid_speed_defines.svh"

module notch_filtered_pid_speed (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_write,
	input  logic [ncpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ncpid_pkg::CFG_DATA_W-1:0]      cfg_data,
	// samples in
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ncpid_pkg::MM_W-1:0]            setpoint_mm,
	input  logic [ncpid_pkg::MM_W-1:0]            measured_mm,
	input  logic                                  timed_out,
	// speed commands out
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ncpid_pkg::OUT_W-1:0]    speed_command
);
	import ncpid_pkg::*;

	cfg_t    cfg_q;
	dp_ctl_t ctl;
	logic    out_hold;

	// config registers; every index in range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:   cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:   cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:   cfg_q.gain_d_per_dt  <= cfg_data[GAIN_W-1:0];
				CFG_INT_LIM:  cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				CFG_DT:       cfg_q.sample_period  <= cfg_data[DT_W-1:0];
				CFG_NOTCH_B1: cfg_q.notch_b1       <= $signed(cfg_data[COEF_W-1:0]);
				CFG_NOTCH_A1: cfg_q.notch_a1       <= $signed(cfg_data[COEF_W-1:0]);
				CFG_NOTCH_A2: cfg_q.notch_a2       <= $signed(cfg_data[COEF_W-1:0]);
			endcase
		end
	end

	// sequencer: step counter, control store, sample drop decision
	ncpid_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measured_mm (measured_mm),
		.timed_out   (timed_out),
		.out_hold    (out_hold),
		.ctl         (ctl)
	);

	// datapath: MAC, notch/derivative/integral state, output register
	ncpid_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.ctl           (ctl),
		.setpoint_mm   (setpoint_mm),
		.measured_mm   (measured_mm),
		.out_ready     (out_ready),
		.out_hold      (out_hold),
		.out_valid     (out_valid),
		.speed_command (speed_command)
	);

	`NCPID_ASSERT_IMP(a_cmd_range, out_valid, (speed_command <= CMD_MAX) && (speed_command >= CMD_MIN), "speed command beyond limit")
	`NCPID_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready after input transfer")
	`NCPID_ASSERT_IMP(a_no_xfer_in_prog, ctl.run, !in_ready, "input taken while program runs")
	`NCPID_ASSERT_NXT(a_result_lands, ctl.run && (ctl.uw.wb == WB_OUT), out_valid, "result step left no result")

endmodule

`default_nettype wire

@@ hw/rtl/ncpid_seq.sv @@
// ----------------------------------------------------------------------------
// ncpid_seq
// Step counter and control store; takes input transfers and drops bad samples.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpid_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ncpid_pkg::MM_W-1:0]    measured_mm,
	input  logic                          timed_out,
	input  logic                          out_hold,
	output ncpid_pkg::dp_ctl_t            ctl
);
	import ncpid_pkg::*;

	logic              busy_q;
	logic              drop_q;
	logic [STEP_W-1:0] step_q;
	ucw_t              uw;
	logic              accept;
	logic              stall;

	assign uw       = ucode(step_q);
	assign in_ready = !busy_q;
	assign accept   = in_valid && !busy_q;
	// result step waits while the output register is full and not being taken
	assign stall    = (uw.wb == WB_OUT) && out_hold;

	always_comb begin
		ctl.load = accept;
		ctl.run  = busy_q && !stall;
		ctl.uw   = uw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			drop_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
			drop_q <= timed_out || (measured_mm >= INVALID_MM);
		end else if (ctl.run) begin
			unique case (uw.seq)
				SEQ_NEXT:  step_q <= step_q + STEP_W'(1);
				SEQ_JDROP: step_q <= drop_q ? uw.target : step_q + STEP_W'(1);
				SEQ_DONE: begin
					busy_q <= 1'b0;
					step_q <= '0;
				end
				default: step_q <= '0;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ncpid_dp.sv @@
// ----------------------------------------------------------------------------
// ncpid_dp
// Shared multiply-accumulate, filter state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpid_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ncpid_pkg::cfg_t                      cfg,
	input  ncpid_pkg::dp_ctl_t                   ctl,
	input  logic [ncpid_pkg::MM_W-1:0]           setpoint_mm,
	input  logic [ncpid_pkg::MM_W-1:0]           measured_mm,
	input  logic                                 out_ready,
	output logic                                 out_hold,
	output logic                                 out_valid,
	output logic signed [ncpid_pkg::OUT_W-1:0]   speed_command
);
	import ncpid_pkg::*;

	logic signed [SIG_W-1:0]   x_q, in1_q, in2_q, y1_q, y2_q, prev_q, smooth_q, integ_q;
	logic signed [SIG_W-1:0]   op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_shf, acc_shi, lim_p, lim_n;
	logic signed [SIG_W-1:0]   sat_val, integ_val;
	logic [ACC_W-1:0]          cmd_mag, cmd_quo;
	logic signed [OUT_W-1:0]   cmd_val;
	logic signed [MM_W:0]      err;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   speed_command_q;

	assign err = $signed({1'b0, setpoint_mm}) - $signed({1'b0, measured_mm});

	always_comb begin
		unique case (ctl.uw.a)
			A_X:      op_a = x_q;
			A_IN1:    op_a = in1_q;
			A_IN2:    op_a = in2_q;
			A_Y1:     op_a = y1_q;
			A_Y2:     op_a = y2_q;
			A_PREV:   op_a = prev_q;
			A_SMOOTH: op_a = smooth_q;
			A_INTEG:  op_a = integ_q;
		endcase
	end

	always_comb begin
		unique case (ctl.uw.b)
			B_ONE:   op_b = ONE_B;
			B_B1:    op_b = MUL_B_W'(cfg.notch_b1);
			B_A1:    op_b = MUL_B_W'(cfg.notch_a1);
			B_A2:    op_b = MUL_B_W'(cfg.notch_a2);
			B_KHOLD: op_b = KHOLD_B;
			B_KNEW:  op_b = KNEW_B;
			B_DT:    op_b = $signed({{(MUL_B_W - DT_W){1'b0}}, cfg.sample_period});
			B_TWO16: op_b = DT_ONE_B;
			B_GP:    op_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, cfg.gain_p});
			B_GI:    op_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, cfg.gain_i});
			B_GD:    op_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, cfg.gain_d_per_dt});
			default: op_b = ONE_B;
		endcase
	end

	// floor rescale and 40-bit saturation (notch output and smoothed difference)
	assign acc_shf = acc_q >>> FRAC_BITS;
	always_comb begin
		if (acc_shf > SIG_MAX64)
			sat_val = SIG_MAX64[SIG_W-1:0];
		else if (acc_shf < SIG_MIN64)
			sat_val = SIG_MIN64[SIG_W-1:0];
		else
			sat_val = acc_shf[SIG_W-1:0];
	end

	// integral clamp
	assign acc_shi = acc_q >>> DT_W;
	assign lim_p   = $signed({{(ACC_W - LIM_W){1'b0}}, cfg.integral_limit});
	assign lim_n   = -lim_p;
	always_comb begin
		if (acc_shi > lim_p)
			integ_val = lim_p[SIG_W-1:0];
		else if (acc_shi < lim_n)
			integ_val = lim_n[SIG_W-1:0];
		else
			integ_val = acc_shi[SIG_W-1:0];
	end

	// command: clamp, then divide by 2^2F toward zero
	assign cmd_mag = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
	assign cmd_quo = cmd_mag >> (2 * FRAC_BITS);
	always_comb begin
		if (acc_q > CMD_CAP)
			cmd_val = CMD_MAX;
		else if (acc_q < CMD_CAP_N)
			cmd_val = CMD_MIN;
		else if (acc_q[ACC_W-1])
			cmd_val = -$signed(cmd_quo[OUT_W-1:0]);
		else
			cmd_val = $signed(cmd_quo[OUT_W-1:0]);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.load)
			x_q <= SIG_W'(err) <<< FRAC_BITS;
		if (ctl.run) begin
			prod_s1 <= op_a * op_b;
			unique case (ctl.uw.acc)
				ACC_NOP:  acc_q <= acc_q;
				ACC_LOAD: acc_q <= ACC_W'(prod_s1);
				ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
				ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_s1);
			endcase
			if (ctl.uw.wb == WB_OUT)
				speed_command_q <= cmd_val;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in1_q    <= '0;
			in2_q    <= '0;
			y1_q     <= '0;
			y2_q     <= '0;
			prev_q   <= '0;
			smooth_q <= '0;
			integ_q  <= '0;
		end else if (ctl.run) begin
			unique case (ctl.uw.wb)
				WB_NOTCH: begin
					in2_q <= in1_q;
					in1_q <= x_q;
					y2_q  <= y1_q;
					y1_q  <= sat_val;
				end
				WB_SMOOTH: begin
					smooth_q <= sat_val;
					prev_q   <= y1_q;
				end
				WB_INTEG: integ_q <= integ_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.run && (ctl.uw.wb == WB_OUT))
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_hold      = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign speed_command = speed_command_q;

endmodule

`default_nettype wire
